// ===== sv/channel_message_deframer_assert.svh =====
// Assertion macros shared by the channel message deframer RTL
`ifndef CHANNEL_MESSAGE_DEFRAMER_ASSERT_SVH
`define CHANNEL_MESSAGE_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CMDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CMDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cmdf_pkg.sv =====
// Types, constants and register codes of the channel message deframer
package cmdf_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int BUF_SIZE_DEF = 512;
    localparam int CHANNELS_MAX = 16;
    localparam int ID_SHIFT     = 4;
    localparam int ID_MASK      = 112;
    localparam int Q_DEPTH      = 2;

    localparam logic [7:0] NEWLINE = 8'd10;

    localparam logic [7:0] ERASE_CMD_RST    = 8'd8;
    localparam logic [7:0] KILL_CMD_RST     = 8'd21;
    localparam logic [7:0] FACE_CMD_RST     = 8'd0;
    localparam logic [8:0] FACE_LEN_RST     = 9'd1;
    localparam logic [7:0] IGNORE_CMD_RST   = 8'd0;
    localparam logic [2:0] HOST_CHANNEL_RST = 3'd0;

    typedef enum logic [2:0] {
        CFG_ERASE_CMD    = 3'd0,
        CFG_KILL_CMD     = 3'd1,
        CFG_FACE_CMD     = 3'd2,
        CFG_FACE_LEN     = 3'd3,
        CFG_IGNORE_CMD   = 3'd4,
        CFG_HOST_CHANNEL = 3'd5
    } t_cfg_idx;

    typedef logic [$clog2(CHANNELS_MAX)-1:0] t_chan;

    typedef struct packed {
        logic [7:0] erase_cmd;
        logic [7:0] kill_cmd;
        logic [7:0] face_cmd;
        logic [8:0] face_len;
        logic [7:0] ignore_cmd;
        logic [2:0] host_channel;
    } t_cfg;

    // Classified input word as it travels through the queue
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [2:0] release_channel;
        logic       is_newline;
        t_chan      id_chan;
    } t_item;

    typedef struct packed {
        logic       accepted;
        logic       wr_en;
        logic [2:0] wr_channel;
        logic [8:0] wr_index;
        logic [7:0] wr_byte;
        logic       done_res;
        logic [2:0] done_channel;
        logic [7:0] done_cmd;
        logic [8:0] done_len;
        logic       dropped;
    } t_result;

endpackage

// ===== sv/cmdf_front.sv =====
// Front stage: accept input words, decode newline and channel id, feed the queue
module cmdf_front #(
    parameter int CHANNELS = cmdf_pkg::CHANNELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_func,
    input  logic [7:0]      i_rx_byte,
    input  logic [2:0]      i_release_channel,
    input  logic            i_q_full,
    output logic            o_push,
    output cmdf_pkg::t_item o_item
);

    localparam logic [7:0] MASK = 8'(cmdf_pkg::ID_MASK);

    logic            r_vld;
    cmdf_pkg::t_item r_item;
    cmdf_pkg::t_item n_item;
    logic [7:0]      id_raw;

    always_comb begin
        id_raw                 = (i_rx_byte & MASK) >> cmdf_pkg::ID_SHIFT;
        n_item.func            = i_func;
        n_item.rx_byte         = i_rx_byte;
        n_item.release_channel = i_release_channel;
        n_item.is_newline      = (i_rx_byte == cmdf_pkg::NEWLINE);
        // out-of-range id falls back to channel 0
        n_item.id_chan         = (32'(id_raw) < CHANNELS) ? cmdf_pkg::t_chan'(id_raw) : '0;
    end

    assign o_push     = r_vld && !i_q_full;
    assign o_in_ready = !r_vld || !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/cmdf_queue.sv =====
// Short queue between the front stage and the message engine
module cmdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmdf_pkg::t_item i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cmdf_pkg::t_item o_data
);

    localparam int AW = (cmdf_pkg::Q_DEPTH > 1) ? $clog2(cmdf_pkg::Q_DEPTH) : 1;
    localparam int CNTW = $clog2(cmdf_pkg::Q_DEPTH + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(cmdf_pkg::Q_DEPTH);
    localparam logic [AW-1:0]   LAST_PTR = AW'(cmdf_pkg::Q_DEPTH - 1);

    cmdf_pkg::t_item r_mem [cmdf_pkg::Q_DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== sv/cmdf_back.sv =====
// Message engine: per-word channel state update and registered result
module cmdf_back #(
    parameter int CHANNELS = cmdf_pkg::CHANNELS_DEF,
    parameter int BUF_SIZE = cmdf_pkg::BUF_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cmdf_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  cmdf_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cmdf_pkg::t_result o_res
);

    localparam int CW = $clog2(CHANNELS);
    localparam int IW = $clog2(BUF_SIZE - 2);
    localparam int WAIT_LIM_I = (2 * CHANNELS > 31) ? 31 : 2 * CHANNELS;
    localparam logic [4:0]    WAIT_LIM = 5'(WAIT_LIM_I);
    localparam logic [IW-1:0] OVF_IDX  = IW'(BUF_SIZE - 3);

    logic                r_in_msg,  n_in_msg;
    logic                r_started, n_started;
    logic                r_counted, n_counted;
    logic [CW-1:0]       r_cur_ch,  n_cur_ch;
    logic [7:0]          r_cur_cmd, n_cur_cmd;
    logic [8:0]          r_rem,     n_rem;
    logic [IW-1:0]       r_widx,    n_widx;
    logic [CHANNELS-1:0] r_full,    n_full;
    logic [4:0]          r_wait,    n_wait;
    logic                r_ovld;
    cmdf_pkg::t_result   r_res,     n_res;

    logic          take;
    logic [CW-1:0] host_ch;
    logic [CW-1:0] id_ch;

    // {counted, remaining} for a freshly set up buffer
    function automatic logic [9:0] f_mode(input logic [7:0] cmd, input cmdf_pkg::t_cfg cfg);
        logic [9:0] m;
        m = '0;
        if (cmd == cfg.erase_cmd || cmd == cfg.kill_cmd) begin
            m = {1'b1, 9'd1};
        end else if (cmd == cfg.face_cmd && cfg.face_len != 9'd0) begin
            m = {1'b1, cfg.face_len};
        end
        return m;
    endfunction

    assign take        = i_q_valid && (!r_ovld || i_out_ready);
    assign o_pop       = take;
    assign o_out_valid = r_ovld;
    assign o_res       = r_res;
    assign host_ch     = (32'(i_cfg.host_channel) < CHANNELS) ? CW'(i_cfg.host_channel) : '0;
    assign id_ch       = CW'(i_item.id_chan);

    always_comb begin
        logic          go;
        logic [CW-1:0] ch;
        logic [7:0]    cmd;
        logic          st;
        logic          cnt_m;
        logic [8:0]    rem;
        logic [IW-1:0] idx;
        logic [IW-1:0] idx_inc;

        n_in_msg  = r_in_msg;
        n_started = r_started;
        n_counted = r_counted;
        n_cur_ch  = r_cur_ch;
        n_cur_cmd = r_cur_cmd;
        n_rem     = r_rem;
        n_widx    = r_widx;
        n_full    = r_full;
        n_wait    = r_wait;
        n_res     = '0;
        go        = 1'b1;
        ch        = r_cur_ch;
        cmd       = r_cur_cmd;
        st        = r_started;
        cnt_m     = r_counted;
        rem       = r_rem;
        idx       = r_widx;
        idx_inc   = r_widx + 1'b1;

        if (i_item.func) begin
            // release a channel buffer
            n_res.accepted = 1'b1;
            if (32'(i_item.release_channel) < CHANNELS) begin
                n_full[CW'(i_item.release_channel)] = 1'b0;
            end
        end else if (!r_in_msg) begin
            n_res.accepted = 1'b1;
            if (!i_item.is_newline) begin
                n_cur_cmd = i_item.rx_byte;
                n_cur_ch  = id_ch;
                n_in_msg  = 1'b1;
                n_started = 1'b0;
                n_wait    = '0;
                if (!r_full[id_ch]) begin
                    n_started              = 1'b1;
                    n_widx                 = '0;
                    {n_counted, n_rem}     = f_mode(i_item.rx_byte, i_cfg);
                end
            end
        end else begin
            if (r_full[r_cur_ch]) begin
                if (r_wait >= WAIT_LIM) begin
                    // waited too long: redirect to the host channel
                    ch            = host_ch;
                    cmd           = i_cfg.ignore_cmd;
                    st            = 1'b0;
                    n_res.dropped = 1'b1;
                end else begin
                    n_wait = r_wait + 1'b1;
                    go     = 1'b0;
                end
            end
            if (go) begin
                n_wait         = '0;
                n_res.accepted = 1'b1;
                if (!st) begin
                    idx          = '0;
                    {cnt_m, rem} = f_mode(cmd, i_cfg);
                end
                idx_inc   = idx + 1'b1;
                n_cur_ch  = ch;
                n_cur_cmd = cmd;
                n_counted = cnt_m;
                n_rem     = rem;
                n_widx    = idx;
                if (!cnt_m && i_item.is_newline) begin
                    n_full[ch]         = 1'b1;
                    n_res.done_res     = 1'b1;
                    n_res.done_channel = 3'(ch);
                    n_res.done_cmd     = cmd;
                    n_res.done_len     = 9'(idx);
                    n_in_msg           = 1'b0;
                    n_started          = 1'b0;
                end else begin
                    n_res.wr_en      = 1'b1;
                    n_res.wr_channel = 3'(ch);
                    n_res.wr_index   = 9'(idx);
                    n_res.wr_byte    = i_item.rx_byte;
                    n_widx           = idx_inc;
                    if (cnt_m && rem == 9'd1) begin
                        n_full[ch]         = 1'b1;
                        n_res.done_res     = 1'b1;
                        n_res.done_channel = 3'(ch);
                        n_res.done_cmd     = cmd;
                        n_res.done_len     = 9'(idx_inc);
                        n_in_msg           = 1'b0;
                        n_started          = 1'b0;
                        n_counted          = 1'b0;
                        n_rem              = '0;
                    end else begin
                        n_started = 1'b1;
                        if (cnt_m) begin
                            n_rem = rem - 1'b1;
                        end
                        if (idx_inc >= OVF_IDX) begin
                            // overflow: continue on the host channel from the start
                            n_res.dropped = 1'b1;
                            n_cur_ch      = host_ch;
                            n_cur_cmd     = i_cfg.ignore_cmd;
                            n_widx        = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg  <= 1'b0;
            r_started <= 1'b0;
            r_counted <= 1'b0;
            r_cur_ch  <= '0;
            r_cur_cmd <= '0;
            r_rem     <= '0;
            r_widx    <= '0;
            r_full    <= '0;
            r_wait    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (take) begin
                r_in_msg  <= n_in_msg;
                r_started <= n_started;
                r_counted <= n_counted;
                r_cur_ch  <= n_cur_ch;
                r_cur_cmd <= n_cur_cmd;
                r_rem     <= n_rem;
                r_widx    <= n_widx;
                r_full    <= n_full;
                r_wait    <= n_wait;
                r_ovld    <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== sv/channel_message_deframer.sv =====
// Channel message deframer top level: config registers, front stage, queue, message engine.
// Path: front register, queue entry, then the engine's registered result word.
// Throughput: one word per cycle while the output is ready; the engine updates state per word.
// A two-entry queue decouples the front stage from the engine and the output register.
// Synchronous active-low reset clears all message state and loads register defaults.
`include "channel_message_deframer_assert.svh"

module channel_message_deframer #(
    parameter int CHANNELS = cmdf_pkg::CHANNELS_DEF,
    parameter int BUF_SIZE = cmdf_pkg::BUF_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [2:0] i_release_channel,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accepted,
    output logic       o_wr_en,
    output logic [2:0] o_wr_channel,
    output logic [8:0] o_wr_index,
    output logic [7:0] o_wr_byte,
    output logic       o_done_res,
    output logic [2:0] o_done_channel,
    output logic [7:0] o_done_cmd,
    output logic [8:0] o_done_len,
    output logic       o_dropped
);

    cmdf_pkg::t_cfg    r_cfg;
    cmdf_pkg::t_item   front_item;
    cmdf_pkg::t_item   q_item;
    cmdf_pkg::t_result res;
    logic              q_push;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              held_word;
    logic              held_side;
    logic              last_write;
    logic              len_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.erase_cmd    <= cmdf_pkg::ERASE_CMD_RST;
            r_cfg.kill_cmd     <= cmdf_pkg::KILL_CMD_RST;
            r_cfg.face_cmd     <= cmdf_pkg::FACE_CMD_RST;
            r_cfg.face_len     <= cmdf_pkg::FACE_LEN_RST;
            r_cfg.ignore_cmd   <= cmdf_pkg::IGNORE_CMD_RST;
            r_cfg.host_channel <= cmdf_pkg::HOST_CHANNEL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                cmdf_pkg::CFG_ERASE_CMD:    r_cfg.erase_cmd    <= i_cfg_data[7:0];
                cmdf_pkg::CFG_KILL_CMD:     r_cfg.kill_cmd     <= i_cfg_data[7:0];
                cmdf_pkg::CFG_FACE_CMD:     r_cfg.face_cmd     <= i_cfg_data[7:0];
                cmdf_pkg::CFG_FACE_LEN:     r_cfg.face_len     <= i_cfg_data;
                cmdf_pkg::CFG_IGNORE_CMD:   r_cfg.ignore_cmd   <= i_cfg_data[7:0];
                cmdf_pkg::CFG_HOST_CHANNEL: r_cfg.host_channel <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    cmdf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_rx_byte         (i_rx_byte),
        .i_release_channel (i_release_channel),
        .i_q_full          (q_full),
        .o_push            (q_push),
        .o_item            (front_item)
    );

    cmdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    cmdf_back #(
        .CHANNELS (CHANNELS),
        .BUF_SIZE (BUF_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_accepted     = res.accepted;
    assign o_wr_en        = res.wr_en;
    assign o_wr_channel   = res.wr_channel;
    assign o_wr_index     = res.wr_index;
    assign o_wr_byte      = res.wr_byte;
    assign o_done_res     = res.done_res;
    assign o_done_channel = res.done_channel;
    assign o_done_cmd     = res.done_cmd;
    assign o_done_len     = res.done_len;
    assign o_dropped      = res.dropped;

    assign held_word  = o_out_valid && !o_accepted;
    assign held_side  = o_wr_en || o_done_res || o_dropped;
    assign last_write = o_out_valid && o_wr_en && o_done_res;
    assign len_ok     = (o_done_len == 9'(o_wr_index + 9'd1));

    `CMDF_ASSERT_SAME(a_held_clean, i_clk, i_rst_n, held_word, !held_side, "held word not clean")
    `CMDF_ASSERT_SAME(a_done_len, i_clk, i_rst_n, last_write, len_ok, "done length off")
    `CMDF_ASSERT_SAME(a_pop_needs_entry, i_clk, i_rst_n, q_pop, q_valid, "pop from empty queue")
    `CMDF_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, q_push, q_valid, "empty after push")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the channel message deframer: predicted result words against the block
module tb;
    import cmdf_pkg::*;

    localparam int CHANNELS   = CHANNELS_DEF;
    localparam int BUF_SIZE   = BUF_SIZE_DEF;
    localparam int WAIT_LIMIT = (2 * CHANNELS > 31) ? 31 : 2 * CHANNELS;

    class frame_scoreboard;
        logic [7:0] erase_cmd, kill_cmd, face_cmd, ignore_cmd;
        logic [8:0] face_len;
        logic [2:0] host_channel;

        logic       in_msg, started, counted;
        logic [2:0] chan;
        logic [7:0] cmd;
        logic [8:0] remaining, windex;
        logic [4:0] wait_cnt;
        logic       full [CHANNELS];

        t_result    pending_results [$];
        int         errors;

        function new();
            erase_cmd    = ERASE_CMD_RST;
            kill_cmd     = KILL_CMD_RST;
            face_cmd     = FACE_CMD_RST;
            face_len     = FACE_LEN_RST;
            ignore_cmd   = IGNORE_CMD_RST;
            host_channel = HOST_CHANNEL_RST;
            in_msg       = 1'b0;
            started      = 1'b0;
            counted      = 1'b0;
            chan         = '0;
            cmd          = '0;
            remaining    = '0;
            windex       = '0;
            wait_cnt     = '0;
            foreach (full[k]) full[k] = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [8:0] val);
            case (idx)
                CFG_ERASE_CMD:    erase_cmd    = val[7:0];
                CFG_KILL_CMD:     kill_cmd     = val[7:0];
                CFG_FACE_CMD:     face_cmd     = val[7:0];
                CFG_FACE_LEN:     face_len     = val;
                CFG_IGNORE_CMD:   ignore_cmd   = val[7:0];
                CFG_HOST_CHANNEL: host_channel = val[2:0];
                default: ;
            endcase
        endfunction

        function logic [2:0] chan_of(logic [7:0] c);
            return (c < CHANNELS) ? c[2:0] : 3'd0;
        endfunction

        function void set_up();
            started = 1'b1;
            windex  = '0;
            if (cmd == erase_cmd || cmd == kill_cmd) begin
                counted   = 1'b1;
                remaining = 9'd1;
            end else if (cmd == face_cmd && face_len != 9'd0) begin
                counted   = 1'b1;
                remaining = face_len;
            end else begin
                counted   = 1'b0;
                remaining = '0;
            end
        endfunction

        function void close_message(inout t_result r);
            full[chan]     = 1'b1;
            r.done_res     = 1'b1;
            r.done_channel = chan;
            r.done_cmd     = cmd;
            r.done_len     = windex;
            in_msg         = 1'b0;
            started        = 1'b0;
            counted        = 1'b0;
            remaining      = '0;
        endfunction

        // Advance the deframer state by one accepted word and queue its result
        function t_result note_word(logic f, logic [7:0] b, logic [2:0] rc);
            t_result    r;
            logic [7:0] id;
            bit         held;
            r    = '0;
            held = 1'b0;
            if (f) begin
                if (rc < CHANNELS) full[rc] = 1'b0;
                r.accepted = 1'b1;
            end else if (!in_msg) begin
                r.accepted = 1'b1;
                if (b != NEWLINE) begin
                    id       = (b & 8'(ID_MASK)) >> ID_SHIFT;
                    cmd      = b;
                    chan     = chan_of(id);
                    in_msg   = 1'b1;
                    started  = 1'b0;
                    wait_cnt = '0;
                    if (!full[chan]) set_up();
                end
            end else begin
                if (full[chan]) begin
                    if (wait_cnt >= WAIT_LIMIT) begin
                        // give up waiting: carry on as an ignore message on the host channel
                        chan      = chan_of(8'(host_channel));
                        cmd       = ignore_cmd;
                        started   = 1'b0;
                        r.dropped = 1'b1;
                    end else begin
                        wait_cnt = wait_cnt + 5'd1;
                        held     = 1'b1;
                    end
                end
                if (!held) begin
                    wait_cnt   = '0;
                    r.accepted = 1'b1;
                    if (!started) set_up();
                    if (!counted && b == NEWLINE) begin
                        close_message(r);
                    end else begin
                        r.wr_en      = 1'b1;
                        r.wr_channel = chan;
                        r.wr_index   = windex;
                        r.wr_byte    = b;
                        windex       = windex + 9'd1;
                        if (counted && remaining == 9'd1) begin
                            close_message(r);
                        end else begin
                            if (counted) remaining = remaining - 9'd1;
                            if (windex >= BUF_SIZE - 3) begin
                                // overflow: keep mode and count, restart on the host channel
                                r.dropped = 1'b1;
                                chan      = chan_of(8'(host_channel));
                                cmd       = ignore_cmd;
                                windex    = '0;
                            end
                        end
                    end
                end
            end
            pending_results.push_back(r);
            return r;
        endfunction

        function void cmp(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result word arrived with nothing expected");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            cmp("accepted", want.accepted, got.accepted);
            cmp("wr_en", want.wr_en, got.wr_en);
            cmp("wr_channel", want.wr_channel, got.wr_channel);
            cmp("wr_index", want.wr_index, got.wr_index);
            cmp("wr_byte", want.wr_byte, got.wr_byte);
            cmp("done_res", want.done_res, got.done_res);
            cmp("done_channel", want.done_channel, got.done_channel);
            cmp("done_cmd", want.done_cmd, got.done_cmd);
            cmp("done_len", want.done_len, got.done_len);
            cmp("dropped", want.dropped, got.dropped);
        endfunction
    endclass

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_cfg_wr_en       = 1'b0;
    logic [2:0] i_cfg_index       = '0;
    logic [8:0] i_cfg_data        = '0;
    logic       i_in_valid        = 1'b0;
    logic       i_func            = 1'b0;
    logic [7:0] i_rx_byte         = '0;
    logic [2:0] i_release_channel = '0;
    logic       i_out_ready       = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_accepted;
    logic       o_wr_en;
    logic [2:0] o_wr_channel;
    logic [8:0] o_wr_index;
    logic [7:0] o_wr_byte;
    logic       o_done_res;
    logic [2:0] o_done_channel;
    logic [7:0] o_done_cmd;
    logic [8:0] o_done_len;
    logic       o_dropped;

    frame_scoreboard sb = new();
    bit calm    = 1'b0;
    bit ovf_due = 1'b0;
    int items   = 0;

    channel_message_deframer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_rx_byte         (i_rx_byte),
        .i_release_channel (i_release_channel),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_accepted        (o_accepted),
        .o_wr_en           (o_wr_en),
        .o_wr_channel      (o_wr_channel),
        .o_wr_index        (o_wr_index),
        .o_wr_byte         (o_wr_byte),
        .o_done_res        (o_done_res),
        .o_done_channel    (o_done_channel),
        .o_done_cmd        (o_done_cmd),
        .o_done_len        (o_done_len),
        .o_dropped         (o_dropped)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result({o_accepted, o_wr_en, o_wr_channel, o_wr_index, o_wr_byte,
                             o_done_res, o_done_channel, o_done_cmd, o_done_len, o_dropped});
    end

    // Present one word, hold it until taken, then predict its result
    task automatic push_word(input logic f, input logic [7:0] b, input logic [2:0] rc,
                             output t_result res);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= f;
        i_rx_byte         <= b;
        i_release_channel <= rc;
        do @(posedge i_clk); while (!o_in_ready);
        res = sb.note_word(f, b, rc);
        items++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        t_result res;
        push_word(1'b0, b, 3'($urandom_range(7)), res);
    endtask

    task automatic put_release(input logic [2:0] c);
        t_result res;
        push_word(1'b1, 8'($urandom_range(255)), c, res);
    endtask

    // Send a link byte as the host would: present it again while it is held off
    task automatic send_held(input logic [7:0] b);
        t_result res;
        int      tries;
        int      release_at;
        tries      = 0;
        release_at = ($urandom_range(99) < 30) ? 1000 : $urandom_range(1, 12);
        push_word(1'b0, b, 3'($urandom_range(7)), res);
        while (!res.accepted) begin
            tries++;
            if (tries == release_at) put_release(sb.chan);
            push_word(1'b0, b, 3'($urandom_range(7)), res);
        end
    endtask

    task automatic send_message();
        logic [7:0] c;
        logic [7:0] b;
        int         kind;
        int         n;
        int         guard;
        bit         by_newline;
        bit         broken;
        kind = $urandom_range(9);
        case (kind)
            0, 1:    c = sb.erase_cmd;
            2:       c = sb.kill_cmd;
            3, 4:    c = sb.face_cmd;
            default: c = 8'($urandom_range(255));
        endcase
        // keep long face messages rare
        if (c == sb.face_cmd && sb.face_len > 16 && $urandom_range(9) != 0)
            c = 8'($urandom_range(255));
        broken     = ($urandom_range(99) < 8);
        by_newline = 1'b0;
        if (c == sb.erase_cmd || c == sb.kill_cmd) begin
            n = 1;
        end else if (c == sb.face_cmd && sb.face_len != 9'd0) begin
            n = sb.face_len;
        end else begin
            by_newline = 1'b1;
            if (ovf_due) begin
                n       = $urandom_range(510, 530);
                ovf_due = 1'b0;
            end else begin
                n = $urandom_range(0, 6);
            end
        end
        if (broken && n > 0) n = $urandom_range(0, n - 1);
        send_held(c);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(255));
            if (by_newline && b == NEWLINE && $urandom_range(99) >= 3) b = 8'h20;
            send_held(b);
        end
        if (by_newline && !broken) send_held(NEWLINE);
        // close any message left open after a redirect
        guard = 0;
        while (sb.in_msg && !broken && guard < 600) begin
            send_held(sb.counted ? 8'($urandom_range(255)) : NEWLINE);
            guard++;
        end
    endtask

    task automatic release_some();
        int start;
        int k;
        start = $urandom_range(CHANNELS - 1);
        for (k = 0; k < CHANNELS; k++)
            if (sb.full[(start + k) % CHANNELS]) break;
        if (k < CHANNELS) put_release(3'((start + k) % CHANNELS));
        else put_release(3'($urandom_range(7)));
    endtask

    task automatic run_phase(input int words, input bit force_ovf);
        int stop;
        int r;
        t_result res;
        stop    = items + words;
        ovf_due = force_ovf;
        while (items < stop) begin
            r = $urandom_range(99);
            if (r < 18) release_some();
            else if (r < 26) push_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                       3'($urandom_range(7)), res);
            else if (r < 29) put_byte(NEWLINE);
            else send_message();
        end
    endtask

    // Stop sending and let every expected result come out
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [8:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] erase, input logic [7:0] kill,
                             input logic [7:0] face, input logic [8:0] flen,
                             input logic [7:0] ignore, input logic [2:0] host);
        write_reg(CFG_ERASE_CMD, {1'b0, erase});
        write_reg(CFG_KILL_CMD, {1'b0, kill});
        write_reg(CFG_FACE_CMD, {1'b0, face});
        write_reg(CFG_FACE_LEN, flen);
        write_reg(CFG_IGNORE_CMD, {1'b0, ignore});
        write_reg(CFG_HOST_CHANNEL, {6'b0, host});
    endtask

    task automatic directed();
        put_byte(NEWLINE);
        put_byte(ERASE_CMD_RST);
        put_byte(8'h00);
        put_release(3'd0);
        put_byte(KILL_CMD_RST);
        put_byte(8'hFF);
        put_byte(8'h7F);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(NEWLINE);
        // channel seven is now full: command taken, first payload byte held off
        put_byte(8'h7F);
        put_byte(8'h41);
        put_release(3'd7);
        put_byte(8'h41);
        put_byte(NEWLINE);
        // face message of one byte takes a newline as payload
        put_byte(FACE_CMD_RST);
        put_byte(NEWLINE);
        put_byte(8'h20);
        put_byte(NEWLINE);
        put_release(3'd0);
        put_release(3'd1);
        put_release(3'd2);
        put_release(3'd7);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed();
        drain();
        configure(8'h00, 8'hFF, 8'h35, 9'd3, 8'h7F, 3'd7);
        run_phase(330, 1'b1);
        drain();
        configure(8'hFF, 8'h00, 8'hFF, 9'd0, 8'hFF, 3'd0);
        run_phase(200, 1'b0);
        drain();
        configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  9'd511, 8'($urandom_range(255)), 3'($urandom_range(7)));
        run_phase(150, 1'b0);
        drain();
        calm = 1'b1;
        configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  9'd1, 8'($urandom_range(255)), 3'($urandom_range(7)));
        run_phase(330, 1'b1);
        drain();
        calm = 1'b0;
        configure(8'h2A, 8'h2A, 8'h2A, 9'd2, NEWLINE, 3'd4);
        run_phase(200, 1'b0);
        drain();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cmdf_pkg.sv
sv/cmdf_front.sv
sv/cmdf_queue.sv
sv/cmdf_back.sv
sv/channel_message_deframer.sv
bench/tb.sv
